// File: rtl/core/dreg_pkg.sv
// Shared types, constants and codes for the device registry table.
package dreg_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int KIND_W   = 3;
  localparam int MAC_W    = 48;
  localparam int TRN_W    = 2;
  localparam int IP_W     = 32;
  localparam int MISS_W   = 8;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 5;
  localparam int COUNT_W  = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FIND   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SETIP  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PING   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd3;

  localparam logic [TRN_W-1:0] TRN_WIRED = 2'd0;
  localparam logic [TRN_W-1:0] TRN_RADIO = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_EN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_LNK = 1'd1;

  localparam logic [MISS_W-1:0] MISS_LIMIT = 8'd255;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [TRN_W-1:0]  trn;
    logic [IP_W-1:0]   ip;
    logic              act;
    logic [MISS_W-1:0] miss;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [MAC_W-1:0]  key;
    logic [TRN_W-1:0]  trn;
    logic [IP_W-1:0]   ip;
    logic              ok;
  } req_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_COMMIT
  } ctrl_state_t;

endpackage

// File: rtl/core/dreg_ifs.sv
// Valid/ready channel interfaces: request, result and configuration write.
interface dreg_in_if;
  import dreg_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [MAC_W-1:0]  mac_key;
  logic [TRN_W-1:0]  transport;
  logic [IP_W-1:0]   ip_value;
  logic              ping_ok;
  modport source (output valid, kind, mac_key, transport, ip_value, ping_ok, input ready);
  modport sink (input valid, kind, mac_key, transport, ip_value, ping_ok, output ready);
endinterface

interface dreg_out_if;
  import dreg_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [TRN_W-1:0]    entry_transport;
  logic [IP_W-1:0]     entry_ip;
  logic                entry_active;
  logic [MISS_W-1:0]   entry_misses;
  logic [COUNT_W-1:0]  entry_count;
  modport source (output valid, status, slot, entry_transport, entry_ip, entry_active,
                  entry_misses, entry_count, input ready);
  modport sink (input valid, status, slot, entry_transport, entry_ip, entry_active,
                entry_misses, entry_count, output ready);
endinterface

interface dreg_cfg_if;
  import dreg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/dreg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dreg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/dreg_ctrl.sv
// Controller state machine: accept, table scan, commit and result handoff.
module dreg_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dreg_pkg::sts_t sts,
  output dreg_pkg::cmd_t cmd
);
  import dreg_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: begin
        if (in_valid) state_nxt = CS_SCAN;
      end
      CS_SCAN: begin
        if (sts.scan_done) state_nxt = CS_COMMIT;
      end
      CS_COMMIT: begin
        if (sts.out_free) state_nxt = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      CS_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      CS_SCAN: begin
        cmd.scan = 1'b1;
      end
      CS_COMMIT: begin
        cmd.commit = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/dreg_dp.sv
// Datapath: request register, entry RAM scan, valid bits, update and result register.
module dreg_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dreg_pkg::cmd_t                    cmd,
  output dreg_pkg::sts_t                    sts,
  input  logic [dreg_pkg::KIND_W-1:0]       in_kind,
  input  logic [dreg_pkg::MAC_W-1:0]        in_mac_key,
  input  logic [dreg_pkg::TRN_W-1:0]        in_transport,
  input  logic [dreg_pkg::IP_W-1:0]         in_ip_value,
  input  logic                              in_ping_ok,
  input  logic                              cfg_valid,
  input  logic [dreg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dreg_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              cfg_ready,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [dreg_pkg::STATUS_W-1:0]     out_status,
  output logic [dreg_pkg::SLOT_W-1:0]       out_slot,
  output logic [dreg_pkg::TRN_W-1:0]        out_entry_transport,
  output logic [dreg_pkg::IP_W-1:0]         out_entry_ip,
  output logic                              out_entry_active,
  output logic [dreg_pkg::MISS_W-1:0]       out_entry_misses,
  output logic [dreg_pkg::COUNT_W-1:0]      out_entry_count
);
  import dreg_pkg::*;

  localparam logic [IDX_W:0] IDX_END = (IDX_W+1)'(TABLE_DEPTH);

  req_t             req_r;
  logic [IDX_W:0]   idx_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  entry_t           ent_r;
  logic             free_fnd_r;
  logic [IDX_W-1:0] free_idx_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [CNT_W-1:0] vcnt_r;
  logic             sweep_r;
  logic             serial_r;

  logic             out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  entry_t              out_ent_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic             issue;
  entry_t           rd_ent;
  logic [ENTRY_W-1:0] rd_data;
  logic             match;
  logic             free_hit;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_ent;
  logic             set_v;
  logic             clr_v;
  logic [IDX_W-1:0] v_idx;
  logic [CNT_W-1:0] cnt_new;
  logic [STATUS_W-1:0] res_st;
  logic [IDX_W-1:0] res_idx;
  entry_t           res_ent;
  logic             elig;

  dreg_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.commit && wr_en),
    .waddr (wr_addr),
    .wdata (wr_ent),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (rd_data)
  );

  assign rd_ent   = entry_t'(rd_data);
  assign issue    = cmd.scan && (idx_r != IDX_END);
  assign match    = cmp_vld_r && !hit_r && valid_r[cmp_idx_r] && (rd_ent.mac == req_r.key);
  assign free_hit = cmp_vld_r && !free_fnd_r && !valid_r[cmp_idx_r];

  assign sts.scan_done = hit_r || ((idx_r == IDX_END) && !cmp_vld_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign cfg_ready = 1'b1;

  // scan pipeline: address out one cycle, compare the next
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r  <= 1'b0;
      hit_r      <= 1'b0;
      free_fnd_r <= 1'b0;
      idx_r      <= '0;
    end else if (cmd.load) begin
      cmp_vld_r  <= 1'b0;
      hit_r      <= 1'b0;
      free_fnd_r <= 1'b0;
      idx_r      <= '0;
    end else begin
      cmp_vld_r <= issue;
      if (issue) idx_r <= idx_r + 1'b1;
      if (match) hit_r <= 1'b1;
      if (free_hit) free_fnd_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r.kind <= in_kind;
      req_r.key  <= in_mac_key;
      req_r.trn  <= in_transport;
      req_r.ip   <= in_ip_value;
      req_r.ok   <= in_ping_ok;
    end
    cmp_idx_r <= idx_r[IDX_W-1:0];
    if (match) begin
      hit_idx_r <= cmp_idx_r;
      ent_r     <= rd_ent;
    end
    if (free_hit) free_idx_r <= cmp_idx_r;
  end

  assign elig = sweep_r &&
                (((ent_r.trn == TRN_WIRED) && serial_r) || (ent_r.trn == TRN_RADIO));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hit_idx_r;
    wr_ent  = ent_r;
    set_v   = 1'b0;
    clr_v   = 1'b0;
    v_idx   = hit_idx_r;
    cnt_new = vcnt_r;
    res_st  = ST_IGNORED;
    res_idx = '0;
    res_ent = '0;
    case (req_r.kind)
      KIND_ADD: begin
        if (hit_r) begin
          wr_ent.trn = req_r.trn;
          wr_en      = 1'b1;
          res_st     = ST_OK;
          res_idx    = hit_idx_r;
          res_ent    = wr_ent;
        end else if (free_fnd_r) begin
          wr_addr = free_idx_r;
          wr_ent  = '{mac: req_r.key, trn: req_r.trn, ip: '0, act: 1'b0, miss: '0};
          wr_en   = 1'b1;
          set_v   = 1'b1;
          v_idx   = free_idx_r;
          cnt_new = vcnt_r + 1'b1;
          res_st  = ST_OK;
          res_idx = free_idx_r;
          res_ent = wr_ent;
        end else begin
          res_st = ST_FULL;
        end
      end
      KIND_REMOVE, KIND_FIND, KIND_SETIP, KIND_PING: begin
        if (!hit_r) begin
          res_st = ST_NOT_FOUND;
        end else begin
          res_st  = ST_OK;
          res_idx = hit_idx_r;
          case (req_r.kind)
            KIND_REMOVE: begin
              clr_v = 1'b1;
              if (vcnt_r != '0) cnt_new = vcnt_r - 1'b1;
            end
            KIND_SETIP: begin
              wr_ent.ip = req_r.ip;
              wr_en     = 1'b1;
            end
            KIND_PING: begin
              if (!elig) begin
                res_st = ST_IGNORED;
              end else if (req_r.ok) begin
                wr_ent.act  = 1'b1;
                wr_ent.miss = '0;
                wr_en       = 1'b1;
              end else begin
                wr_ent.act = 1'b0;
                if (ent_r.miss != MISS_LIMIT) wr_ent.miss = ent_r.miss + 1'b1;
                wr_en = 1'b1;
              end
            end
            default: ;
          endcase
          res_ent = wr_ent;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      vcnt_r      <= '0;
      sweep_r     <= 1'b0;
      serial_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SWEEP_EN:   sweep_r  <= cfg_data[0];
          CFG_SERIAL_LNK: serial_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        if (set_v) valid_r[v_idx] <= 1'b1;
        if (clr_v) valid_r[v_idx] <= 1'b0;
        vcnt_r      <= cnt_new;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_st;
      out_slot_r   <= SLOT_W'(res_idx);
      out_ent_r    <= res_ent;
      out_count_r  <= COUNT_W'(cnt_new);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_slot            = out_slot_r;
  assign out_entry_transport = out_ent_r.trn;
  assign out_entry_ip        = out_ent_r.ip;
  assign out_entry_active    = out_ent_r.act;
  assign out_entry_misses    = out_ent_r.miss;
  assign out_entry_count     = out_count_r;

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'($countones(valid_r)) == vcnt_r)
    else $error("valid count out of step with valid bits");

  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && hit_r) |-> valid_r[hit_idx_r])
    else $error("matched slot not valid at commit");

  a_no_dup_add: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && set_v) |-> (!hit_r && !valid_r[v_idx]))
    else $error("add claimed an occupied slot or duplicated a key");

endmodule

// File: rtl/core/device_registry_table.sv
// Device registry table top level: controller, datapath and channel hookup.
// The scan walks the entry RAM read port one slot after another and ends at the first match,
// or after the last slot on a miss, so a key in a lower slot gives its result sooner.
// An item is taken only when idle, so a new one is not accepted before the last is committed.
// The result register holds a finished item while the next one is accepted and scanned.
// Reset (rst_n low, synchronous) clears all valid bits, the entry count and both config bits.
module device_registry_table (
  input logic        clk,
  input logic        rst_n,
  dreg_in_if.sink    in_ch,
  dreg_out_if.source out_ch,
  dreg_cfg_if.sink   cfg_ch
);
  import dreg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dreg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dreg_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_kind             (in_ch.kind),
    .in_mac_key          (in_ch.mac_key),
    .in_transport        (in_ch.transport),
    .in_ip_value         (in_ch.ip_value),
    .in_ping_ok          (in_ch.ping_ok),
    .cfg_valid           (cfg_ch.valid),
    .cfg_index           (cfg_ch.index),
    .cfg_data            (cfg_ch.data),
    .cfg_ready           (cfg_ch.ready),
    .out_ready           (out_ch.ready),
    .out_valid           (out_ch.valid),
    .out_status          (out_ch.status),
    .out_slot            (out_ch.slot),
    .out_entry_transport (out_ch.entry_transport),
    .out_entry_ip        (out_ch.entry_ip),
    .out_entry_active    (out_ch.entry_active),
    .out_entry_misses    (out_ch.entry_misses),
    .out_entry_count     (out_ch.entry_count)
  );

endmodule

// File: verif/tb.sv
// Testbench for the device registry table: random and directed requests, checked against a mirror.
module tb;
  import dreg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;
  localparam logic [TRN_W-1:0]  TRN_OTHER_A  = 2'd2;
  localparam logic [TRN_W-1:0]  TRN_OTHER_B  = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [TRN_W-1:0]    trn;
    logic [IP_W-1:0]     ip;
    logic                act;
    logic [MISS_W-1:0]   miss;
    logic [COUNT_W-1:0]  count;
  } reply_t;

  class registry_mirror;
    bit                used[TABLE_DEPTH];
    logic [MAC_W-1:0]  macs[TABLE_DEPTH];
    logic [TRN_W-1:0]  trns[TABLE_DEPTH];
    logic [IP_W-1:0]   ips[TABLE_DEPTH];
    logic              acts[TABLE_DEPTH];
    logic [MISS_W-1:0] misses[TABLE_DEPTH];
    int unsigned       n_valid;
    bit                sweep_on;
    bit                serial_on;
    reply_t            pending_replies[$];
    int                mismatches;
    int                replies_checked;
    int                requests_seen;
    int                status_seen[4];

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_SWEEP_EN) sweep_on = val[0];
      else if (idx == CFG_SERIAL_LNK) serial_on = val[0];
    endfunction

    function reply_t report(logic [STATUS_W-1:0] st, int s);
      reply_t r;
      r = '0;
      r.status = st;
      if (s >= 0) begin
        r.slot = s[SLOT_W-1:0];
        r.trn  = trns[s];
        r.ip   = ips[s];
        r.act  = acts[s];
        r.miss = misses[s];
      end
      r.count = n_valid[COUNT_W-1:0];
      return r;
    endfunction

    function void note_request(req_t q);
      int s;
      int i;
      bit elig;
      reply_t r;
      requests_seen++;
      s = -1;
      if (q.kind > KIND_PING) begin
        r = report(ST_IGNORED, -1);
      end else begin
        for (i = 0; i < TABLE_DEPTH; i++)
          if (s < 0 && used[i] && macs[i] == q.key) s = i;
        if (q.kind == KIND_ADD) begin
          if (s < 0) begin
            for (i = 0; i < TABLE_DEPTH; i++)
              if (s < 0 && !used[i]) s = i;
            if (s >= 0) begin
              used[s]   = 1'b1;
              macs[s]   = q.key;
              ips[s]    = '0;
              acts[s]   = 1'b0;
              misses[s] = '0;
              n_valid++;
            end
          end
          if (s < 0) begin
            r = report(ST_FULL, -1);
          end else begin
            trns[s] = q.trn;
            r = report(ST_OK, s);
          end
        end else if (s < 0) begin
          r = report(ST_NOT_FOUND, -1);
        end else begin
          case (q.kind)
            KIND_REMOVE: begin
              used[s] = 1'b0;
              if (n_valid > 0) n_valid--;
              r = report(ST_OK, s);
            end
            KIND_SETIP: begin
              ips[s] = q.ip;
              r = report(ST_OK, s);
            end
            KIND_PING: begin
              elig = sweep_on &&
                     ((trns[s] == TRN_WIRED && serial_on) || trns[s] == TRN_RADIO);
              if (!elig) begin
                r = report(ST_IGNORED, s);
              end else begin
                if (q.ok) begin
                  acts[s]   = 1'b1;
                  misses[s] = '0;
                end else begin
                  acts[s] = 1'b0;
                  if (misses[s] != MISS_LIMIT) misses[s] = misses[s] + 1'b1;
                end
                r = report(ST_OK, s);
              end
            end
            default: begin
              r = report(ST_OK, s);
            end
          endcase
        end
      end
      pending_replies.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      replies_checked++;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reply: st=%0d slot=%0d trn=%0d ip=%h act=%0d miss=%0d cnt=%0d",
                   got.status, got.slot, got.trn, got.ip, got.act, got.miss, got.count);
        return;
      end
      want = pending_replies.pop_front();
      status_seen[want.status]++;
      if (got.status !== want.status || got.slot !== want.slot || got.trn !== want.trn ||
          got.ip !== want.ip || got.act !== want.act || got.miss !== want.miss ||
          got.count !== want.count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("reply mismatch %0d: want st=%0d slot=%0d trn=%0d ip=%h act=%0d miss=%0d cnt=%0d",
                   mismatches, want.status, want.slot, want.trn, want.ip, want.act, want.miss,
                   want.count);
          $display("                    got  st=%0d slot=%0d trn=%0d ip=%h act=%0d miss=%0d cnt=%0d",
                   got.status, got.slot, got.trn, got.ip, got.act, got.miss, got.count);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   quiet;
  bit   long_hold_done;
  int   settings_used;

  registry_mirror mirror = new();

  dreg_in_if  in_ch();
  dreg_out_if out_ch();
  dreg_cfg_if cfg_ch();

  device_registry_table i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        mirror.check_reply({out_ch.status, out_ch.slot, out_ch.entry_transport, out_ch.entry_ip,
                            out_ch.entry_active, out_ch.entry_misses, out_ch.entry_count});
      if (in_ch.valid && in_ch.ready)
        mirror.note_request({in_ch.kind, in_ch.mac_key, in_ch.transport, in_ch.ip_value,
                             in_ch.ping_ok});
      if (cfg_ch.valid && cfg_ch.ready)
        mirror.set_reg(cfg_ch.index, cfg_ch.data);
    end
  end

  // result side: random stalls, one long hold so the block backs up
  initial begin
    int n;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_ch.ready <= 1'b1;
      end else if (!long_hold_done && mirror.replies_checked >= 100) begin
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 10);
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for the block");
    $display("Verification failed");
    $finish;
  end

  task automatic send_req(input logic [KIND_W-1:0] kind, input logic [MAC_W-1:0] key,
                          input logic [TRN_W-1:0] trn, input logic [IP_W-1:0] ip,
                          input logic ok);
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 10);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.mac_key   <= key;
    in_ch.transport <= trn;
    in_ch.ip_value  <= ip;
    in_ch.ping_ok   <= ok;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (mirror.pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic apply_settings(input bit sweep, input bit serial);
    int k;
    drain();
    for (k = 0; k < 2; k++) begin
      @(negedge clk);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= (k == 0) ? CFG_SWEEP_EN : CFG_SERIAL_LNK;
      cfg_ch.data  <= (k == 0) ? sweep : serial;
      do @(posedge clk); while (!cfg_ch.ready);
      @(negedge clk);
      cfg_ch.valid <= 1'b0;
    end
    settings_used++;
  endtask

  // mostly requests on a small key pool so entries get reused; some stray keys and kinds
  task automatic run_mix(input int count, input int pool_n, input int add_pct);
    logic [MAC_W-1:0]  pool[64];
    logic [MAC_W-1:0]  key;
    logic [KIND_W-1:0] kd;
    int k;
    int pick;
    pool[0] = MAC_W'({$urandom, $urandom});
    for (k = 1; k < pool_n; k++)
      pool[k] = (k % 2) ? pool[0] ^ (48'd1 << $urandom_range(0, 47))
                        : MAC_W'({$urandom, $urandom});
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0) key = MAC_W'({$urandom, $urandom});
      else key = pool[$urandom_range(0, pool_n - 1)];
      if ($urandom_range(0, 99) < add_pct) begin
        kd = KIND_ADD;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 20) kd = KIND_REMOVE;
        else if (pick < 45) kd = KIND_FIND;
        else if (pick < 65) kd = KIND_SETIP;
        else if (pick < 95) kd = KIND_PING;
        else kd = KIND_SPARE_A + KIND_W'($urandom_range(0, 2));
      end
      send_req(kd, key, TRN_W'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [MAC_W-1:0] keys[$];
    logic [MAC_W-1:0] k_lo;
    logic [MAC_W-1:0] k_hi;
    logic [MAC_W-1:0] k_mid;
    logic [MAC_W-1:0] k_sat;
    int i;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_ADD;
    in_ch.mac_key   = '0;
    in_ch.transport = TRN_WIRED;
    in_ch.ip_value  = '0;
    in_ch.ping_ok   = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = CFG_SWEEP_EN;
    cfg_ch.data     = '0;
    k_lo  = '0;
    k_hi  = '1;
    k_mid = 48'h0123_4567_89ab;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    apply_settings(1'b0, 1'b0);

    // empty table, unused kinds, claims, refresh, ignored ping, slot reuse
    send_req(KIND_FIND, k_lo, TRN_WIRED, '0, 1'b0);
    send_req(KIND_REMOVE, k_lo, TRN_WIRED, '0, 1'b0);
    send_req(KIND_SETIP, k_lo, TRN_WIRED, '1, 1'b0);
    send_req(KIND_PING, k_lo, TRN_WIRED, '0, 1'b1);
    send_req(KIND_SPARE_A, k_hi, TRN_OTHER_B, '1, 1'b1);
    send_req(KIND_SPARE_B, k_lo, TRN_WIRED, '0, 1'b0);
    send_req(KIND_ADD, k_lo, TRN_WIRED, '0, 1'b0);
    send_req(KIND_ADD, k_hi, TRN_RADIO, '1, 1'b1);
    send_req(KIND_ADD, k_mid, TRN_OTHER_B, '0, 1'b0);
    send_req(KIND_ADD, k_lo, TRN_OTHER_A, '0, 1'b0);
    send_req(KIND_FIND, k_lo, TRN_WIRED, '0, 1'b0);
    send_req(KIND_SETIP, k_hi, TRN_WIRED, '1, 1'b0);
    send_req(KIND_SETIP, k_mid, TRN_WIRED, 32'h0a00_0001, 1'b0);
    send_req(KIND_PING, k_hi, TRN_WIRED, '0, 1'b0);
    send_req(KIND_REMOVE, k_lo, TRN_WIRED, '0, 1'b0);
    send_req(KIND_ADD, 48'd1, TRN_WIRED, '0, 1'b0);
    send_req(KIND_FIND, k_lo, TRN_WIRED, '0, 1'b0);
    send_req(KIND_SPARE_C, k_hi, TRN_OTHER_B, '1, 1'b1);

    apply_settings(1'b1, 1'b0);
    send_req(KIND_PING, k_mid, TRN_WIRED, '0, 1'b1);
    send_req(KIND_PING, 48'd1, TRN_WIRED, '0, 1'b1);
    send_req(KIND_PING, k_hi, TRN_WIRED, '0, 1'b0);
    send_req(KIND_PING, k_hi, TRN_WIRED, '0, 1'b1);
    apply_settings(1'b1, 1'b1);
    send_req(KIND_PING, 48'd1, TRN_WIRED, '0, 1'b0);
    send_req(KIND_PING, 48'd1, TRN_WIRED, '0, 1'b1);

    run_mix(250, 40, 55);
    apply_settings(1'b1, 1'b0);
    run_mix(200, 36, 20);
    apply_settings(1'b0, 1'b1);
    run_mix(80, 40, 40);
    apply_settings(1'b1, 1'b1);

    // empty the table, then drive one entry's miss count into saturation
    drain();
    for (i = 0; i < TABLE_DEPTH; i++)
      if (mirror.used[i]) keys.push_back(mirror.macs[i]);
    foreach (keys[j]) send_req(KIND_REMOVE, keys[j], TRN_WIRED, '0, 1'b0);
    k_sat = MAC_W'({$urandom, $urandom});
    send_req(KIND_ADD, k_sat, TRN_RADIO, '0, 1'b0);
    for (i = 0; i < 270; i++) begin
      if (i % 50 == 49) send_req(KIND_FIND, k_sat, TRN_WIRED, '0, 1'b0);
      else send_req(KIND_PING, k_sat, TRN_W'($urandom_range(0, 3)), $urandom, 1'b0);
    end
    send_req(KIND_PING, k_sat, TRN_WIRED, '0, 1'b1);
    send_req(KIND_FIND, k_sat, TRN_WIRED, '0, 1'b0);

    quiet = 1'b1;
    run_mix(100, 40, 45);

    drain();
    repeat (40) @(posedge clk);

    $display("Ran %0d requests over %0d register settings, incl. a full table and miss saturation.",
             mirror.requests_seen, settings_used);
    $display("Replies: ok %0d, not found %0d, full %0d, ignored %0d; %0d mismatches.",
             mirror.status_seen[ST_OK], mirror.status_seen[ST_NOT_FOUND],
             mirror.status_seen[ST_FULL], mirror.status_seen[ST_IGNORED], mirror.mismatches);
    if (mirror.mismatches == 0 && mirror.pending_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/dreg_pkg.sv
rtl/core/dreg_ifs.sv
rtl/core/dreg_ram.sv
rtl/core/dreg_ctrl.sv
rtl/core/dreg_dp.sv
rtl/core/device_registry_table.sv
verif/tb.sv
